>>> rtl/lpcp_pkg.sv
// ---------------------------------------------------------------------------
// lpcp_pkg: shared types and constants for lidar point camera projection
// Register indexes, fixed field widths and the control word of the divide cells.
// ---------------------------------------------------------------------------
package lpcp_pkg;

	// default widths of the projection datapath
	localparam int COEF_BITS_DEF  = 32;
	localparam int COORD_BITS_DEF = 18;

	// fixed field widths
	localparam int SLOT_BITS   = 32;
	localparam int CFG_BITS    = 64;
	localparam int IDX_BITS    = 3;
	localparam int PIX_BITS    = 16;
	localparam int COLOR_BITS  = 8;
	localparam int RANGE_BITS  = 17;
	localparam int SIZE_BITS   = 32;
	localparam int NUM_COEF    = 6;

	// color scaling
	localparam logic [COLOR_BITS-1:0] COLOR_MAX = 8'd255;
	localparam logic [RANGE_BITS-1:0] GREEN_DIV = 17'd10000;
	localparam logic [RANGE_BITS-1:0] RANGE_RESET = 17'd100000;

	// configuration register indexes
	typedef enum logic [IDX_BITS-1:0] {
		REG_ROW0_LO  = 3'd0,
		REG_ROW0_HI  = 3'd1,
		REG_ROW1_LO  = 3'd2,
		REG_ROW1_HI  = 3'd3,
		REG_ROW2_LO  = 3'd4,
		REG_ROW2_HI  = 3'd5,
		REG_IMG_SIZE = 3'd6,
		REG_MAX_RANGE = 3'd7
	} reg_idx_t;

	// control word handed along the divide chain
	typedef struct packed {
		logic valid;
		logic drop;
		logic sat_b;
		logic sat_g;
	} ctrl_t;

endpackage

>>> rtl/lidar_point_camera_projection.sv
// ---------------------------------------------------------------------------
// lidar_point_camera_projection: lidar point to image pixel
// Projects a lidar point through a 3x4 matrix, divides by depth in a chain of
// divide cells, drops points off the image and attaches an overlay color.
// ---------------------------------------------------------------------------
//  channel   handshake              payload
//  in        in_valid / in_stall    point_x, point_y, point_z
//  out       out_valid / out_stall  pixel_col, pixel_row, out_x/y/z, dot_*
//  cfg       cfg_valid / cfg_ready  cfg_index, cfg_data
//
//  one point per cycle while not stalled; stages: multiply, sum, range check,
//  16 divide cells (one quotient bit each), output register
//  a stall while out_valid is high freezes the whole pipeline and stalls the input
//  reset clears valid flags and the configuration registers to their reset values
// ---------------------------------------------------------------------------
module lidar_point_camera_projection #(
	parameter int COEF_BITS  = lpcp_pkg::COEF_BITS_DEF,
	parameter int COORD_BITS = lpcp_pkg::COORD_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [lpcp_pkg::IDX_BITS-1:0]       cfg_index,
	input  logic [lpcp_pkg::CFG_BITS-1:0]       cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [COORD_BITS-1:0]        point_x,
	input  logic signed [COORD_BITS-1:0]        point_y,
	input  logic signed [COORD_BITS-1:0]        point_z,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [lpcp_pkg::PIX_BITS-1:0]       pixel_col,
	output logic [lpcp_pkg::PIX_BITS-1:0]       pixel_row,
	output logic signed [COORD_BITS-1:0]        out_x,
	output logic signed [COORD_BITS-1:0]        out_y,
	output logic signed [COORD_BITS-1:0]        out_z,
	output logic [lpcp_pkg::COLOR_BITS-1:0]     dot_red,
	output logic [lpcp_pkg::COLOR_BITS-1:0]     dot_green,
	output logic [lpcp_pkg::COLOR_BITS-1:0]     dot_blue
);

	localparam int VB    = COORD_BITS + 1;
	localparam int PW    = COEF_BITS + VB;
	localparam int RW    = PW + 2;
	localparam int REMW  = RW - 1;
	localparam int WIDE  = REMW + lpcp_pkg::PIX_BITS;
	localparam int AW    = COORD_BITS + 8;
	localparam int CREMW = COORD_BITS + 7;
	localparam int EW    = CREMW + lpcp_pkg::RANGE_BITS;
	localparam int NCELL = lpcp_pkg::PIX_BITS;

	// configuration registers
	logic [lpcp_pkg::CFG_BITS-1:0]    coef_q [lpcp_pkg::NUM_COEF];
	logic [lpcp_pkg::SIZE_BITS-1:0]   img_size_q;
	logic [lpcp_pkg::RANGE_BITS-1:0]  range_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < lpcp_pkg::NUM_COEF; i++) coef_q[i] <= '0;
			img_size_q <= '0;
			range_q    <= lpcp_pkg::RANGE_RESET;
		end else if (cfg_valid) begin
			case (lpcp_pkg::reg_idx_t'(cfg_index))
				lpcp_pkg::REG_ROW0_LO:   coef_q[0] <= cfg_data;
				lpcp_pkg::REG_ROW0_HI:   coef_q[1] <= cfg_data;
				lpcp_pkg::REG_ROW1_LO:   coef_q[2] <= cfg_data;
				lpcp_pkg::REG_ROW1_HI:   coef_q[3] <= cfg_data;
				lpcp_pkg::REG_ROW2_LO:   coef_q[4] <= cfg_data;
				lpcp_pkg::REG_ROW2_HI:   coef_q[5] <= cfg_data;
				lpcp_pkg::REG_IMG_SIZE:  img_size_q <= cfg_data[lpcp_pkg::SIZE_BITS-1:0];
				lpcp_pkg::REG_MAX_RANGE: range_q <= cfg_data[lpcp_pkg::RANGE_BITS-1:0];
				default: ;
			endcase
		end
	end

	// coefficient slots
	logic signed [COEF_BITS-1:0] k [3][4];
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			k[r][0] = coef_q[2*r][COEF_BITS-1:0];
			k[r][1] = coef_q[2*r][lpcp_pkg::SLOT_BITS +: COEF_BITS];
			k[r][2] = coef_q[2*r+1][COEF_BITS-1:0];
			k[r][3] = coef_q[2*r+1][lpcp_pkg::SLOT_BITS +: COEF_BITS];
		end
	end

	// global advance
	logic en;
	logic out_valid_q;
	assign en       = ~(out_valid_q & out_stall);
	assign in_stall = ~en;

	// stage 1: products with camera vector (-y, -z, x)
	logic                       valid_s1;
	logic signed [PW-1:0]       prod_s1 [3][3];
	logic signed [COORD_BITS-1:0] x_s1, y_s1, z_s1;
	logic signed [VB-1:0]       v [3];

	always_comb begin
		v[0] = -VB'(point_y);
		v[1] = -VB'(point_z);
		v[2] = VB'(point_x);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s1 <= 1'b0;
		else if (en) valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++)
				for (int j = 0; j < 3; j++)
					prod_s1[r][j] <= PW'(k[r][j]) * PW'(v[j]);
			x_s1 <= point_x;
			y_s1 <= point_y;
			z_s1 <= point_z;
		end
	end

	// stage 2: row sums and 255*x
	logic                         valid_s2;
	logic signed [RW-1:0]         r_s2 [3];
	logic signed [AW-1:0]         a_s2;
	logic signed [COORD_BITS-1:0] x_s2, y_s2, z_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s2 <= 1'b0;
		else if (en) valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++)
				r_s2[r] <= RW'(prod_s1[r][0]) + RW'(prod_s1[r][1])
					+ RW'(prod_s1[r][2]) + RW'(k[r][3]);
			a_s2 <= (AW'(x_s1) <<< 8) - AW'(x_s1);
			x_s2 <= x_s1;
			y_s2 <= y_s1;
			z_s2 <= z_s1;
		end
	end

	// stage 3: depth and range checks, divider setup
	lpcp_pkg::ctrl_t              ctrl_c [NCELL+1];
	logic [REMW-1:0]              rem0_c [NCELL+1];
	logic [REMW-1:0]              rem1_c [NCELL+1];
	logic [REMW-1:0]              den_c  [NCELL+1];
	logic [lpcp_pkg::PIX_BITS-1:0]   q0_c [NCELL+1];
	logic [lpcp_pkg::PIX_BITS-1:0]   q1_c [NCELL+1];
	logic [CREMW-1:0]             cremb_c [NCELL+1];
	logic [CREMW-1:0]             cremg_c [NCELL+1];
	logic [lpcp_pkg::RANGE_BITS-1:0] cden_c [NCELL+1];
	logic [lpcp_pkg::COLOR_BITS-1:0] qb_c [NCELL+1];
	logic [lpcp_pkg::COLOR_BITS-1:0] qg_c [NCELL+1];
	logic signed [COORD_BITS-1:0] x_c [NCELL+1];
	logic signed [COORD_BITS-1:0] y_c [NCELL+1];
	logic signed [COORD_BITS-1:0] z_c [NCELL+1];

	logic                          drop_n, sat_b_n, sat_g_n;
	logic [REMW-1:0]               d0_n, d1_n;
	logic [CREMW-1:0]              ca_n;
	logic [lpcp_pkg::RANGE_BITS-1:0] range_eff;
	logic [WIDE-1:0]               den_sh;
	logic                          bad [2];

	always_comb begin
		range_eff = (range_q == '0) ? lpcp_pkg::RANGE_BITS'(1) : range_q;
		den_sh    = WIDE'(r_s2[2][REMW-1:0]) << lpcp_pkg::PIX_BITS;
		for (int i = 0; i < 2; i++) begin
			if (r_s2[i][RW-1])
				bad[i] = ((RW+1)'(r_s2[i]) + (RW+1)'(r_s2[2])) <= (RW+1)'(0);
			else
				bad[i] = WIDE'(r_s2[i][REMW-1:0]) >= den_sh;
		end
		drop_n = (r_s2[2] <= RW'(0)) | bad[0] | bad[1];
		d0_n   = r_s2[0][RW-1] ? '0 : r_s2[0][REMW-1:0];
		d1_n   = r_s2[1][RW-1] ? '0 : r_s2[1][REMW-1:0];
		ca_n   = a_s2[AW-1] ? '0 : a_s2[CREMW-1:0];
		sat_b_n = EW'(ca_n) >= (EW'(range_eff) << lpcp_pkg::COLOR_BITS);
		sat_g_n = EW'(ca_n) >= (EW'(lpcp_pkg::GREEN_DIV) << lpcp_pkg::COLOR_BITS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ctrl_c[0] <= '0;
		else if (en) ctrl_c[0] <= '{valid: valid_s2, drop: drop_n,
			sat_b: sat_b_n, sat_g: sat_g_n};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem0_c[0]  <= d0_n;
			rem1_c[0]  <= d1_n;
			den_c[0]   <= r_s2[2][REMW-1:0];
			q0_c[0]    <= '0;
			q1_c[0]    <= '0;
			cremb_c[0] <= ca_n;
			cremg_c[0] <= ca_n;
			cden_c[0]  <= range_eff;
			qb_c[0]    <= '0;
			qg_c[0]    <= '0;
			x_c[0]     <= x_s2;
			y_c[0]     <= y_s2;
			z_c[0]     <= z_s2;
		end
	end

	// divide chain, most significant quotient bit first
	generate
		for (genvar c = 0; c < NCELL; c++) begin : g_cell
			lpcp_cell #(
				.REM_BITS  (REMW),
				.CREM_BITS (CREMW),
				.BIT       (NCELL - 1 - c)
			) u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.en      (en),
				.ctrl_i  (ctrl_c[c]),
				.rem0_i  (rem0_c[c]),
				.rem1_i  (rem1_c[c]),
				.den_i   (den_c[c]),
				.q0_i    (q0_c[c]),
				.q1_i    (q1_c[c]),
				.cremb_i (cremb_c[c]),
				.cremg_i (cremg_c[c]),
				.cden_i  (cden_c[c]),
				.qb_i    (qb_c[c]),
				.qg_i    (qg_c[c]),
				.ctrl_o  (ctrl_c[c+1]),
				.rem0_o  (rem0_c[c+1]),
				.rem1_o  (rem1_c[c+1]),
				.den_o   (den_c[c+1]),
				.q0_o    (q0_c[c+1]),
				.q1_o    (q1_c[c+1]),
				.cremb_o (cremb_c[c+1]),
				.cremg_o (cremg_c[c+1]),
				.cden_o  (cden_c[c+1]),
				.qb_o    (qb_c[c+1]),
				.qg_o    (qg_c[c+1])
			);

			// point coordinates ride along
			always_ff @(posedge clk) begin
				if (en) begin
					x_c[c+1] <= x_c[c];
					y_c[c+1] <= y_c[c];
					z_c[c+1] <= z_c[c];
				end
			end
		end
	endgenerate

	// image bounds and output word
	lpcp_pkg::ctrl_t                 cf;
	logic                            keep;
	logic [lpcp_pkg::COLOR_BITS-1:0] blue_n, green_n;

	always_comb begin
		cf   = ctrl_c[NCELL];
		keep = cf.valid & ~cf.drop
			& (q0_c[NCELL] < img_size_q[lpcp_pkg::PIX_BITS-1:0])
			& (q1_c[NCELL] < img_size_q[lpcp_pkg::SIZE_BITS-1:lpcp_pkg::PIX_BITS]);
		blue_n  = cf.sat_b ? lpcp_pkg::COLOR_MAX : qb_c[NCELL];
		green_n = cf.sat_g ? lpcp_pkg::COLOR_MAX : qg_c[NCELL];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (en) out_valid_q <= keep;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pixel_col <= q0_c[NCELL];
			pixel_row <= q1_c[NCELL];
			out_x     <= x_c[NCELL];
			out_y     <= y_c[NCELL];
			out_z     <= z_c[NCELL];
			dot_blue  <= blue_n;
			dot_green <= green_n;
			dot_red   <= lpcp_pkg::COLOR_MAX - blue_n;
		end
	end

	assign out_valid = out_valid_q;

endmodule

>>> rtl/lpcp_cell.sv
// ---------------------------------------------------------------------------
// lpcp_cell: one restoring divide step
// Resolves quotient bit BIT of column and row, and of blue and green when
// BIT is below the color width, then registers everything for the next cell.
// ---------------------------------------------------------------------------
module lpcp_cell #(
	parameter int REM_BITS  = 54,
	parameter int CREM_BITS = 25,
	parameter int BIT       = 15
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  lpcp_pkg::ctrl_t                   ctrl_i,
	input  logic [REM_BITS-1:0]               rem0_i,
	input  logic [REM_BITS-1:0]               rem1_i,
	input  logic [REM_BITS-1:0]               den_i,
	input  logic [lpcp_pkg::PIX_BITS-1:0]     q0_i,
	input  logic [lpcp_pkg::PIX_BITS-1:0]     q1_i,
	input  logic [CREM_BITS-1:0]              cremb_i,
	input  logic [CREM_BITS-1:0]              cremg_i,
	input  logic [lpcp_pkg::RANGE_BITS-1:0]   cden_i,
	input  logic [lpcp_pkg::COLOR_BITS-1:0]   qb_i,
	input  logic [lpcp_pkg::COLOR_BITS-1:0]   qg_i,
	output lpcp_pkg::ctrl_t                   ctrl_o,
	output logic [REM_BITS-1:0]               rem0_o,
	output logic [REM_BITS-1:0]               rem1_o,
	output logic [REM_BITS-1:0]               den_o,
	output logic [lpcp_pkg::PIX_BITS-1:0]     q0_o,
	output logic [lpcp_pkg::PIX_BITS-1:0]     q1_o,
	output logic [CREM_BITS-1:0]              cremb_o,
	output logic [CREM_BITS-1:0]              cremg_o,
	output logic [lpcp_pkg::RANGE_BITS-1:0]   cden_o,
	output logic [lpcp_pkg::COLOR_BITS-1:0]   qb_o,
	output logic [lpcp_pkg::COLOR_BITS-1:0]   qg_o
);

	localparam int WIDE  = REM_BITS + lpcp_pkg::PIX_BITS;
	localparam int CWIDE = CREM_BITS + lpcp_pkg::RANGE_BITS;

	logic [WIDE-1:0]                    dsh;
	logic [WIDE-1:0]                    r0_ext, r1_ext;
	logic                               ge0, ge1;
	logic [REM_BITS-1:0]                rem0_n, rem1_n;
	logic [lpcp_pkg::PIX_BITS-1:0]      q0_n, q1_n;
	logic [CREM_BITS-1:0]               cremb_n, cremg_n;
	logic [lpcp_pkg::COLOR_BITS-1:0]    qb_n, qg_n;

	// pixel step, shared divisor
	always_comb begin
		dsh    = WIDE'(den_i) << BIT;
		r0_ext = WIDE'(rem0_i);
		r1_ext = WIDE'(rem1_i);
		ge0    = r0_ext >= dsh;
		ge1    = r1_ext >= dsh;
		rem0_n = ge0 ? REM_BITS'(r0_ext - dsh) : rem0_i;
		rem1_n = ge1 ? REM_BITS'(r1_ext - dsh) : rem1_i;
		q0_n   = q0_i;
		q1_n   = q1_i;
		q0_n[BIT] = ge0;
		q1_n[BIT] = ge1;
	end

	// color step only for the low quotient bits
	generate
		if (BIT < lpcp_pkg::COLOR_BITS) begin : g_color
			logic [CWIDE-1:0] bsh, gsh, b_ext, g_ext;
			logic             geb, geg;
			always_comb begin
				bsh   = CWIDE'(cden_i) << BIT;
				gsh   = CWIDE'(lpcp_pkg::GREEN_DIV) << BIT;
				b_ext = CWIDE'(cremb_i);
				g_ext = CWIDE'(cremg_i);
				geb   = b_ext >= bsh;
				geg   = g_ext >= gsh;
				cremb_n = geb ? CREM_BITS'(b_ext - bsh) : cremb_i;
				cremg_n = geg ? CREM_BITS'(g_ext - gsh) : cremg_i;
				qb_n  = qb_i;
				qg_n  = qg_i;
				qb_n[BIT] = geb;
				qg_n[BIT] = geg;
			end
		end else begin : g_pass
			always_comb begin
				cremb_n = cremb_i;
				cremg_n = cremg_i;
				qb_n    = qb_i;
				qg_n    = qg_i;
			end
		end
	endgenerate

	// control register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_o <= '0;
		end else if (en) begin
			ctrl_o <= ctrl_i;
		end
	end

	// data registers
	always_ff @(posedge clk) begin
		if (en) begin
			rem0_o  <= rem0_n;
			rem1_o  <= rem1_n;
			den_o   <= den_i;
			q0_o    <= q0_n;
			q1_o    <= q1_n;
			cremb_o <= cremb_n;
			cremg_o <= cremg_n;
			cden_o  <= cden_i;
			qb_o    <= qb_n;
			qg_o    <= qg_n;
		end
	end

endmodule

>>> sim/testbench.sv
// ---------------------------------------------------------------------------
// testbench: lidar point camera projection
// Loads several projection matrices and image sizes, streams directed and
// random lidar points with bursty input and patterned output stalls, and
// compares every emitted pixel word with a built-in integer predictor.
// ---------------------------------------------------------------------------
module testbench;

	localparam int CB = 18;

	typedef struct {
		logic signed [CB-1:0] x, y, z;
	} point_t;

	typedef struct {
		logic [lpcp_pkg::PIX_BITS-1:0]   col, row;
		logic signed [CB-1:0]            x, y, z;
		logic [lpcp_pkg::COLOR_BITS-1:0] red, green, blue;
	} pixel_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [lpcp_pkg::IDX_BITS-1:0] cfg_index = '0;
	logic [lpcp_pkg::CFG_BITS-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [CB-1:0] point_x = '0, point_y = '0, point_z = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [lpcp_pkg::PIX_BITS-1:0] pixel_col, pixel_row;
	logic signed [CB-1:0] out_x, out_y, out_z;
	logic [lpcp_pkg::COLOR_BITS-1:0] dot_red, dot_green, dot_blue;

	// shadow of the configuration registers
	logic [63:0] shadow_reg [8];

	point_t point_q[$];
	pixel_t pixel_q[$];
	int     errors = 0;
	int     burst_left = 0;
	int     gap_left = 0;
	int     stall_mode = 0;
	int     stall_win = 0;

	lidar_point_camera_projection #(.COEF_BITS(32), .COORD_BITS(CB)) i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.point_x(point_x), .point_y(point_y), .point_z(point_z),
		.out_valid(out_valid), .out_stall(out_stall),
		.pixel_col(pixel_col), .pixel_row(pixel_row),
		.out_x(out_x), .out_y(out_y), .out_z(out_z),
		.dot_red(dot_red), .dot_green(dot_green), .dot_blue(dot_blue)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// one matrix row dotted with (-y, -z, x, 1)
	function automatic longint row_sum(logic [63:0] lo, logic [63:0] hi,
			longint a, longint b, longint c);
		return longint'($signed(lo[31:0])) * a + longint'($signed(lo[63:32])) * b
			+ longint'($signed(hi[31:0])) * c + longint'($signed(hi[63:32]));
	endfunction

	function automatic logic [7:0] clamp_color(longint v);
		if (v < 0) return 8'd0;
		if (v > 255) return 8'd255;
		return v[7:0];
	endfunction

	// projects one point, returns 1 when it lands on the image
	function automatic bit project_point(point_t p, output pixel_t q);
		longint x, y, z, r0, r1, r2, col, row, rng;
		x = p.x;
		y = p.y;
		z = p.z;
		q = '{default: '0};
		r0 = row_sum(shadow_reg[lpcp_pkg::REG_ROW0_LO], shadow_reg[lpcp_pkg::REG_ROW0_HI],
			-y, -z, x);
		r1 = row_sum(shadow_reg[lpcp_pkg::REG_ROW1_LO], shadow_reg[lpcp_pkg::REG_ROW1_HI],
			-y, -z, x);
		r2 = row_sum(shadow_reg[lpcp_pkg::REG_ROW2_LO], shadow_reg[lpcp_pkg::REG_ROW2_HI],
			-y, -z, x);
		if (r2 <= 0) return 0;
		col = r0 / r2;
		row = r1 / r2;
		if (col < 0 || row < 0
				|| col >= longint'(shadow_reg[lpcp_pkg::REG_IMG_SIZE][15:0])
				|| row >= longint'(shadow_reg[lpcp_pkg::REG_IMG_SIZE][31:16]))
			return 0;
		rng = longint'(shadow_reg[lpcp_pkg::REG_MAX_RANGE][16:0]);
		if (rng == 0) rng = 1;
		q.col = col[15:0];
		q.row = row[15:0];
		q.x = p.x;
		q.y = p.y;
		q.z = p.z;
		q.blue = clamp_color((255 * x) / rng);
		q.green = clamp_color((255 * x) / 10000);
		q.red = 8'd255 - q.blue;
		return 1;
	endfunction

	// input driver: bursts with random gaps, payload held while stalled
	always @(posedge clk) begin
		pixel_t q;
		point_t p;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				p.x = point_x;
				p.y = point_y;
				p.z = point_z;
				if (project_point(p, q)) pixel_q = {pixel_q, q};
			end
			if (in_valid && in_stall) begin
				// hold the stalled word
			end else if (gap_left > 0 || point_q.size() == 0) begin
				in_valid <= 1'b0;
				if (gap_left > 0) gap_left--;
			end else begin
				p = point_q.pop_front();
				in_valid <= 1'b1;
				point_x <= p.x;
				point_y <= p.y;
				point_z <= p.z;
				if (burst_left > 0) burst_left--;
				else begin
					burst_left = $urandom_range(0, 40);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
				end
			end
		end
	end

	// output monitor with a windowed stall pattern
	always @(posedge clk) begin
		pixel_t e;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (pixel_q.size() == 0) begin
					$error("unexpected word col=%0d row=%0d", pixel_col, pixel_row);
					errors++;
				end else begin
					e = pixel_q.pop_front();
					if (pixel_col !== e.col) begin
						$error("pixel_col exp %0d got %0d", e.col, pixel_col); errors++;
					end
					if (pixel_row !== e.row) begin
						$error("pixel_row exp %0d got %0d", e.row, pixel_row); errors++;
					end
					if (out_x !== e.x) begin
						$error("out_x exp %0d got %0d", e.x, out_x); errors++;
					end
					if (out_y !== e.y) begin
						$error("out_y exp %0d got %0d", e.y, out_y); errors++;
					end
					if (out_z !== e.z) begin
						$error("out_z exp %0d got %0d", e.z, out_z); errors++;
					end
					if (dot_red !== e.red) begin
						$error("dot_red exp %0d got %0d", e.red, dot_red); errors++;
					end
					if (dot_green !== e.green) begin
						$error("dot_green exp %0d got %0d", e.green, dot_green); errors++;
					end
					if (dot_blue !== e.blue) begin
						$error("dot_blue exp %0d got %0d", e.blue, dot_blue); errors++;
					end
				end
			end
			if (stall_win == 0) begin
				stall_win = $urandom_range(10, 80);
				stall_mode = $urandom_range(0, 3);
			end
			stall_win--;
			case (stall_mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 9) == 0);
				2: out_stall <= ($urandom_range(0, 1) == 0);
				default: out_stall <= ($urandom_range(0, 9) != 0);
			endcase
		end
	end

	task automatic write_reg(lpcp_pkg::reg_idx_t idx, logic [63:0] d);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		shadow_reg[idx] = d;
	endtask

	// pinhole camera with the depth offset t added to the forward distance
	task automatic load_camera(int fx, int fy, int cx, int cy, int t,
			int w, int h, int rng);
		write_reg(lpcp_pkg::REG_ROW0_LO, {32'sd0, fx});
		write_reg(lpcp_pkg::REG_ROW0_HI, {cx * t, cx});
		write_reg(lpcp_pkg::REG_ROW1_LO, {fy, 32'sd0});
		write_reg(lpcp_pkg::REG_ROW1_HI, {cy * t, cy});
		write_reg(lpcp_pkg::REG_ROW2_LO, 64'd0);
		write_reg(lpcp_pkg::REG_ROW2_HI, {t, 32'sd1});
		write_reg(lpcp_pkg::REG_IMG_SIZE, {32'd0, h[15:0], w[15:0]});
		write_reg(lpcp_pkg::REG_MAX_RANGE, {47'd0, rng[16:0]});
	endtask

	// waits until every point is sent and every expected word is out, then lets the pipe drain
	task automatic drain();
		while (point_q.size() != 0 || in_valid) @(posedge clk);
		while (pixel_q.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic add_point(int x, int y, int z);
		point_t p;
		p.x = CB'(x);
		p.y = CB'(y);
		p.z = CB'(z);
		point_q = {point_q, p};
	endtask

	// mostly points in front of the camera inside the view cone, some noise
	task automatic add_random(int n, int t);
		int x, span;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 4) == 0) begin
				add_point($urandom, $urandom, $urandom);
			end else begin
				x = $urandom_range(1, 131071);
				if (t != 0 && $urandom_range(0, 1) == 0) x = -x;
				span = ((x < 0 ? -x : x) + t) * 3 / 4;
				if (span > 131071) span = 131071;
				if (span < 1) span = 1;
				add_point(x, $signed($urandom_range(0, 2 * span)) - span,
					$signed($urandom_range(0, 2 * span)) - span);
			end
		end
	endtask

	initial begin
		shadow_reg = '{default: 64'd0};
		shadow_reg[lpcp_pkg::REG_MAX_RANGE] = 64'd100000;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// reset values: zero matrix and zero image, everything dropped
		add_point(10000, 0, 0);
		add_point(-131072, 131071, -131072);
		drain();

		// typical camera, directed edges of the image
		load_camera(500, 500, 320, 240, 0, 640, 480, 100000);
		add_point(10000, 0, 0);
		add_point(0, 0, 0);
		add_point(-5000, 0, 0);
		add_point(1000, 641, 0);
		add_point(1000, -638, 0);
		add_point(1000, -640, 0);
		add_point(1000, 0, -478);
		add_point(1000, 0, -480);
		add_point(9000, 100, 100);
		add_point(131071, 131071, -131072);
		add_point(131071, -131072, 131071);
		add_point(131071, 0, 0);
		add_point(-131072, 0, 0);
		add_random(300, 0);
		drain();

		// depth offset lets negative forward distance through, zero range
		load_camera(300, 400, 32000, 32000, 200000, 65535, 65535, 0);
		add_point(-131072, 0, 0);
		add_point(-1, 0, 0);
		add_point(131071, -131072, -131072);
		add_point(1, 131071, 131071);
		add_random(300, 200000);
		drain();

		// tiny image, largest range
		load_camera(500, 500, 0, 0, 0, 1, 1, 131071);
		add_point(1000, 0, 0);
		add_point(1000, -1, -1);
		add_point(1000, 1, 1);
		add_random(200, 0);
		drain();

		// extreme coefficients
		write_reg(lpcp_pkg::REG_ROW0_LO, 64'h7FFF_FFFF_8000_0000);
		write_reg(lpcp_pkg::REG_ROW0_HI, 64'h8000_0000_7FFF_FFFF);
		write_reg(lpcp_pkg::REG_ROW1_LO, 64'h8000_0000_7FFF_FFFF);
		write_reg(lpcp_pkg::REG_ROW1_HI, 64'h7FFF_FFFF_8000_0000);
		write_reg(lpcp_pkg::REG_ROW2_LO, 64'h0000_0001_FFFF_FFFF);
		write_reg(lpcp_pkg::REG_ROW2_HI, 64'h7FFF_FFFF_0000_7FFF);
		write_reg(lpcp_pkg::REG_IMG_SIZE, 64'h0000_0000_FFFF_FFFF);
		write_reg(lpcp_pkg::REG_MAX_RANGE, 64'd1);
		add_point(131071, 131071, 131071);
		add_point(-131072, -131072, -131072);
		add_random(250, 0);
		drain();

		// random small matrices and sizes
		for (int k = 0; k < 3; k++) begin
			write_reg(lpcp_pkg::REG_ROW0_LO, {$signed($urandom_range(0, 2000)) - 1000,
				$signed($urandom_range(0, 2000)) - 1000});
			write_reg(lpcp_pkg::REG_ROW0_HI,
				{$urandom, $signed($urandom_range(0, 2000)) - 1000});
			write_reg(lpcp_pkg::REG_ROW1_LO, {$signed($urandom_range(0, 2000)) - 1000,
				$signed($urandom_range(0, 2000)) - 1000});
			write_reg(lpcp_pkg::REG_ROW1_HI,
				{$urandom, $signed($urandom_range(0, 2000)) - 1000});
			write_reg(lpcp_pkg::REG_ROW2_LO, {$signed($urandom_range(0, 8)) - 4,
				$signed($urandom_range(0, 8)) - 4});
			write_reg(lpcp_pkg::REG_ROW2_HI, {32'($urandom_range(0, 1 << 20)),
				32'($urandom_range(1, 16))});
			write_reg(lpcp_pkg::REG_IMG_SIZE, {32'd0, $urandom});
			write_reg(lpcp_pkg::REG_MAX_RANGE, {47'd0, 17'($urandom_range(1, 131071))});
			add_random(150, 0);
			drain();
		end

		if (errors == 0) begin
			$display("PASS lidar_point_camera_projection");
		end else begin
			$display("FAIL lidar_point_camera_projection");
		end
		$finish;
	end

	// run limit
	initial begin
		#2000000;
		$display("FAIL lidar_point_camera_projection");
		$finish;
	end

endmodule

>>> files.f
rtl/lpcp_pkg.sv
rtl/lpcp_cell.sv
rtl/lidar_point_camera_projection.sv
sim/testbench.sv
